>>> sv/ffha_pkg.sv
`timescale 1ns / 1ps
package ffha_pkg;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int SIZE_W     = 11;
   localparam int OFFSET_W   = 10;
   localparam int STATUS_W   = 2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_RD_H,
      OP_STEP,
      OP_NOFIT,
      OP_BAD,
      OP_GRANT,
      OP_SPLIT,
      OP_LINK_SPLIT,
      OP_FREE_CUR,
      OP_RD_NEXT,
      OP_ABS_NEXT,
      OP_WR_CUR,
      OP_LINK_CUR,
      OP_RD_PRIOR,
      OP_RD_P,
      OP_ABS_PREV,
      OP_RES_OK,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free;
      logic bad_addr;
      logic rd_hdr;
      logic rd_free;
      logic fits;
      logic split_now;
      logic rd_past;
      logic next_in;
      logic h_zero;
      logic prev_ok;
      logic out_slot;
   } dp_stat_type;

endpackage

>>> sv/ffha_ctrl.sv
`timescale 1ns / 1ps
module ffha_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  ffha_pkg::dp_stat_type stat,
   output ffha_pkg::dp_cmd_type  cmd
);

   typedef enum logic [17:0] {
      S_IDLE   = 18'h00001,
      S_A_RD   = 18'h00002,
      S_A_EVAL = 18'h00004,
      S_A_SPL  = 18'h00008,
      S_A_LNK  = 18'h00010,
      S_F_CHK  = 18'h00020,
      S_F_EVAL = 18'h00040,
      S_F_RDN  = 18'h00080,
      S_F_NEV  = 18'h00100,
      S_F_WRC  = 18'h00200,
      S_F_LNK  = 18'h00400,
      S_F_PRV  = 18'h00800,
      S_F_PEV0 = 18'h01000,
      S_F_PEV  = 18'h02000,
      S_F_WRP  = 18'h04000,
      S_F_LNP  = 18'h08000,
      S_RES    = 18'h10000,
      S_DONE   = 18'h20000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = ffha_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = ffha_pkg::OP_LOAD;
               state_in = S_A_RD;
            end
         end
         S_A_RD: begin
            if (stat.is_free) begin
               state_in = S_F_CHK;
            end else begin
               cmd.op   = ffha_pkg::OP_RD_H;
               state_in = S_A_EVAL;
            end
         end
         S_A_EVAL: begin
            if (stat.fits) begin
               cmd.op   = ffha_pkg::OP_GRANT;
               state_in = stat.split_now ? S_A_SPL : S_RES;
            end else if (stat.rd_past) begin
               cmd.op   = ffha_pkg::OP_NOFIT;
               state_in = S_DONE;
            end else begin
               cmd.op   = ffha_pkg::OP_STEP;
               state_in = S_A_RD;
            end
         end
         S_A_SPL: begin
            cmd.op   = ffha_pkg::OP_SPLIT;
            state_in = S_A_LNK;
         end
         S_A_LNK: begin
            cmd.op   = ffha_pkg::OP_LINK_SPLIT;
            state_in = S_RES;
         end
         S_F_CHK: begin
            if (stat.bad_addr) begin
               cmd.op   = ffha_pkg::OP_BAD;
               state_in = S_DONE;
            end else begin
               cmd.op   = ffha_pkg::OP_RD_H;
               state_in = S_F_EVAL;
            end
         end
         S_F_EVAL: begin
            if (!stat.rd_hdr) begin
               cmd.op   = ffha_pkg::OP_BAD;
               state_in = S_DONE;
            end else begin
               cmd.op   = ffha_pkg::OP_FREE_CUR;
               state_in = S_F_RDN;
            end
         end
         S_F_RDN: begin
            if (stat.next_in) begin
               cmd.op   = ffha_pkg::OP_RD_NEXT;
               state_in = S_F_NEV;
            end else begin
               state_in = S_F_PRV;
            end
         end
         S_F_NEV: begin
            if (stat.rd_hdr && stat.rd_free) begin
               cmd.op   = ffha_pkg::OP_ABS_NEXT;
               state_in = S_F_WRC;
            end else begin
               state_in = S_F_PRV;
            end
         end
         S_F_WRC: begin
            cmd.op   = ffha_pkg::OP_WR_CUR;
            state_in = S_F_LNK;
         end
         S_F_LNK: begin
            cmd.op   = ffha_pkg::OP_LINK_CUR;
            state_in = S_F_PRV;
         end
         S_F_PRV: begin
            if (stat.h_zero) begin
               state_in = S_RES;
            end else begin
               cmd.op   = ffha_pkg::OP_RD_PRIOR;
               state_in = S_F_PEV0;
            end
         end
         S_F_PEV0: begin
            cmd.op   = ffha_pkg::OP_RD_P;
            state_in = S_F_PEV;
         end
         S_F_PEV: begin
            if (stat.prev_ok) begin
               cmd.op   = ffha_pkg::OP_ABS_PREV;
               state_in = S_F_WRP;
            end else begin
               state_in = S_RES;
            end
         end
         S_F_WRP: begin
            cmd.op   = ffha_pkg::OP_WR_CUR;
            state_in = S_F_LNP;
         end
         S_F_LNP: begin
            cmd.op   = ffha_pkg::OP_LINK_CUR;
            state_in = S_RES;
         end
         S_RES: begin
            cmd.op   = ffha_pkg::OP_RES_OK;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_slot) begin
               cmd.op   = ffha_pkg::OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/ffha_dp.sv
`timescale 1ns / 1ps
module ffha_dp #(
   parameter int HEAP_BYTES   = 1024,
   parameter int HEADER_BYTES = 32,
   parameter int ALIGN_BYTES  = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ffha_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ffha_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  ffha_pkg::dp_cmd_type            cmd,
   output ffha_pkg::dp_stat_type           stat
);

   localparam int GRANULES = HEAP_BYTES / ALIGN_BYTES;
   localparam int GW       = $clog2(GRANULES);
   localparam int AL       = $clog2(ALIGN_BYTES);
   localparam int BW       = $clog2(HEAP_BYTES + 1);
   localparam int SW       = BW + 1;
   localparam int CW       = ((SW > 12) ? SW : 12) + 1;
   localparam int MW       = BW + 2;

   localparam logic [CW-1:0] HDR_C  = CW'(HEADER_BYTES);
   localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);
   localparam logic [MW-1:0] ENTRY0 = {2'b11, BW'(HEAP_BYTES - HEADER_BYTES)};

   // entry word: {header_here, block_free, block_bytes}
   logic [MW-1:0] main_mem [GRANULES];
   logic [GW-1:0] prior_mem [GRANULES];
   logic [GRANULES-1:0] valid_ff;

   logic          mw_en;
   logic [GW-1:0] mw_addr;
   logic [MW-1:0] mw_data;
   logic [GW-1:0] mr_addr;
   logic          pw_en;
   logic [GW-1:0] pw_addr;
   logic [GW-1:0] pw_data;

   logic [MW-1:0] rd_word_ff;
   logic          rd_valid_ff;
   logic          rd_zero_ff;
   logic [GW-1:0] prior_rd_ff;

   logic                                  cmd_ff, cmd_in;
   logic [CW-1:0]                         want_ff, want_in;
   logic                                  bad_ff, bad_in;
   logic [GW-1:0]                         h_ff, h_in;
   logic [BW-1:0]                         cur_ff, cur_in;
   logic [BW-1:0]                         rem_ff, rem_in;
   logic [GW-1:0]                         fol_ff, fol_in;
   logic                                  fol_ok_ff, fol_ok_in;
   logic [GW-1:0]                         n_ff, n_in;
   logic [GW-1:0]                         p_ff, p_in;
   logic [ffha_pkg::STATUS_W-1:0]         res_st_ff, res_st_in;
   logic [ffha_pkg::OFFSET_W-1:0]         res_off_ff, res_off_in;
   logic [ffha_pkg::SIZE_W-1:0]           res_size_ff, res_size_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [ffha_pkg::RSP_DATA_W-1:0]       rsp_data_ff, rsp_data_in;

   logic [MW-1:0] rd_word;
   logic          rd_hdr;
   logic          rd_free;
   logic [BW-1:0] rd_bytes;
   logic [CW-1:0] h_byte;
   logic [CW-1:0] rd_next;
   logic [CW-1:0] cur_next;
   logic [CW-1:0] req_size;
   logic [CW-1:0] req_off;
   logic [CW-1:0] free_h;
   logic [CW-1:0] split_at;
   logic          fits;

   assign rd_word  = rd_valid_ff ? rd_word_ff : (rd_zero_ff ? ENTRY0 : '0);
   assign rd_hdr   = rd_word[MW-1];
   assign rd_free  = rd_word[MW-2];
   assign rd_bytes = rd_word[BW-1:0];

   assign h_byte   = CW'(h_ff) << AL;
   assign rd_next  = h_byte + HDR_C + CW'(rd_bytes);
   assign cur_next = h_byte + HDR_C + CW'(cur_ff);
   assign req_size = CW'(req_tdata[ffha_pkg::SIZE_W-1:0]);
   assign req_off  = CW'(req_tdata[ffha_pkg::SIZE_W +: ffha_pkg::OFFSET_W]);
   assign free_h   = req_off - HDR_C;
   assign split_at = h_byte + HDR_C + want_ff;
   assign fits     = rd_free && (want_ff <= CW'(rd_bytes));

   assign stat.is_free   = cmd_ff;
   assign stat.bad_addr  = bad_ff;
   assign stat.rd_hdr    = rd_hdr;
   assign stat.rd_free   = rd_free;
   assign stat.fits      = fits;
   assign stat.split_now = (CW'(rd_bytes) - want_ff) >= HDR_C;
   assign stat.rd_past   = rd_next >= HEAP_C;
   assign stat.next_in   = cur_next < HEAP_C;
   assign stat.h_zero    = (h_ff == '0);
   assign stat.prev_ok   = (p_ff < h_ff) && rd_hdr && rd_free;
   assign stat.out_slot  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      cmd_in       = cmd_ff;
      want_in      = want_ff;
      bad_in       = bad_ff;
      h_in         = h_ff;
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      fol_in       = fol_ff;
      fol_ok_in    = fol_ok_ff;
      n_in         = n_ff;
      p_in         = p_ff;
      res_st_in    = res_st_ff;
      res_off_in   = res_off_ff;
      res_size_in  = res_size_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mw_en        = 1'b0;
      mw_addr      = h_ff;
      mw_data      = '0;
      mr_addr      = h_ff;
      pw_en        = 1'b0;
      pw_addr      = n_ff;
      pw_data      = h_ff;
      case (cmd.op)
         ffha_pkg::OP_LOAD: begin
            cmd_in  = req_tuser;
            want_in = ((req_size + CW'(ALIGN_BYTES - 1)) >> AL) << AL;
            bad_in  = (req_off < HDR_C) || (req_off[AL-1:0] != '0) || (free_h >= HEAP_C);
            h_in    = (req_tuser == ffha_pkg::CMD_FREE) ? free_h[AL +: GW] : '0;
         end
         ffha_pkg::OP_RD_H: begin
            mr_addr = h_ff;
         end
         ffha_pkg::OP_STEP: begin
            h_in = rd_next[AL +: GW];
         end
         ffha_pkg::OP_NOFIT: begin
            res_st_in   = ffha_pkg::ST_NOFIT;
            res_off_in  = '0;
            res_size_in = '0;
         end
         ffha_pkg::OP_BAD: begin
            res_st_in   = ffha_pkg::ST_BADFREE;
            res_off_in  = '0;
            res_size_in = '0;
         end
         ffha_pkg::OP_GRANT: begin
            cur_in    = stat.split_now ? BW'(want_ff) : rd_bytes;
            rem_in    = BW'(CW'(rd_bytes) - want_ff - HDR_C);
            fol_in    = rd_next[AL +: GW];
            fol_ok_in = rd_next < HEAP_C;
            mw_en     = 1'b1;
            mw_addr   = h_ff;
            mw_data   = {2'b10, cur_in};
         end
         ffha_pkg::OP_SPLIT: begin
            n_in    = split_at[AL +: GW];
            mw_en   = 1'b1;
            mw_addr = split_at[AL +: GW];
            mw_data = {2'b11, rem_ff};
            pw_en   = 1'b1;
            pw_addr = split_at[AL +: GW];
            pw_data = h_ff;
         end
         ffha_pkg::OP_LINK_SPLIT: begin
            pw_en   = fol_ok_ff;
            pw_addr = fol_ff;
            pw_data = n_ff;
         end
         ffha_pkg::OP_FREE_CUR: begin
            cur_in  = rd_bytes;
            mw_en   = 1'b1;
            mw_addr = h_ff;
            mw_data = {2'b11, rd_bytes};
         end
         ffha_pkg::OP_RD_NEXT: begin
            n_in    = cur_next[AL +: GW];
            mr_addr = cur_next[AL +: GW];
         end
         ffha_pkg::OP_ABS_NEXT: begin
            cur_in  = BW'(CW'(cur_ff) + HDR_C + CW'(rd_bytes));
            mw_en   = 1'b1;
            mw_addr = n_ff;
            mw_data = '0;
         end
         ffha_pkg::OP_WR_CUR: begin
            mw_en   = 1'b1;
            mw_addr = h_ff;
            mw_data = {2'b11, cur_ff};
         end
         ffha_pkg::OP_LINK_CUR: begin
            pw_en   = cur_next < HEAP_C;
            pw_addr = cur_next[AL +: GW];
            pw_data = h_ff;
         end
         ffha_pkg::OP_RD_PRIOR: begin
            mr_addr = h_ff;
         end
         ffha_pkg::OP_RD_P: begin
            p_in    = prior_rd_ff;
            mr_addr = prior_rd_ff;
         end
         ffha_pkg::OP_ABS_PREV: begin
            cur_in  = BW'(CW'(rd_bytes) + HDR_C + CW'(cur_ff));
            h_in    = p_ff;
            mw_en   = 1'b1;
            mw_addr = h_ff;
            mw_data = '0;
         end
         ffha_pkg::OP_RES_OK: begin
            res_st_in   = ffha_pkg::ST_OK;
            res_off_in  = ffha_pkg::OFFSET_W'(h_byte + HDR_C);
            res_size_in = ffha_pkg::SIZE_W'(cur_ff);
         end
         ffha_pkg::OP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {1'b0, res_size_ff, res_off_ff, res_st_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mw_en) begin
         main_mem[mw_addr] <= mw_data;
      end
      if (pw_en) begin
         prior_mem[pw_addr] <= pw_data;
      end
      rd_word_ff  <= main_mem[mr_addr];
      prior_rd_ff <= prior_mem[mr_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= ffha_pkg::CMD_ALLOC;
         bad_ff       <= 1'b0;
      end else begin
         if (mw_en) begin
            valid_ff[mw_addr] <= 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
         cmd_ff       <= cmd_in;
         bad_ff       <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[mr_addr] || (mw_en && (mw_addr == mr_addr));
      rd_zero_ff  <= (mr_addr == '0);
      want_ff     <= want_in;
      h_ff        <= h_in;
      cur_ff      <= cur_in;
      rem_ff      <= rem_in;
      fol_ff      <= fol_in;
      fol_ok_ff   <= fol_ok_in;
      n_ff        <= n_in;
      p_ff        <= p_in;
      res_st_ff   <= res_st_in;
      res_off_ff  <= res_off_in;
      res_size_ff <= res_size_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> sv/first_fit_heap_allocator_unit.sv
`timescale 1ns / 1ps
// First-fit heap allocator. One request in on req_*, exactly one response out on rsp_*.
// req_tuser selects the command (0 allocate, 1 free). An allocate rounds its size up
// to the alignment and walks the block chain from the start for the first free block
// that fits, splitting off the remainder when it can hold a header. A free releases
// a block and merges it with free neighbors on both sides.
// An allocate reads and then evaluates each block it examines; a free checks the
// address, reads its header and merges with the next and then the previous block.
// Each step costs one read of the block table, so the walk of up to 32 blocks dominates.
// One request is in flight at a time; req_tready is high only while idle.
// Responses sit in an output register: when rsp_tready is low the response holds
// and the next request waits until its own response can enter that register.
// Reset (synchronous, active high) leaves one free block covering the whole arena;
// the table has a per-entry valid bit, so no clearing pass is needed.
module first_fit_heap_allocator_unit #(
   parameter int HEAP_BYTES   = 1024,
   parameter int HEADER_BYTES = 32,
   parameter int ALIGN_BYTES  = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // request_size [10:0], block_offset [20:11], zero [23:21]
   input  logic [ffha_pkg::REQ_DATA_W-1:0] req_tdata,
   // command [0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status [1:0], data_offset [11:2], granted_size [22:12], zero [23]
   output logic [ffha_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   ffha_pkg::dp_cmd_type  cmd;
   ffha_pkg::dp_stat_type stat;

   ffha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ffha_dp #(
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .ALIGN_BYTES  (ALIGN_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

>>> sv/ffha_checker.sv
`timescale 1ns / 1ps
module ffha_checker #(
   parameter int HEADER_BYTES = 32
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ffha_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // failed requests carry no offset and no size
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == ffha_pkg::ST_NOFIT
                     || rsp_tdata[1:0] == ffha_pkg::ST_BADFREE)
      |-> rsp_tdata[22:2] == '0)
      else $error("failed response with payload");

   // a granted data area sits past its header; an empty block at the arena end wraps to 0
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == ffha_pkg::ST_OK
      |-> (rsp_tdata[11:2] >= 10'(HEADER_BYTES)) || (rsp_tdata[11:2] == '0))
      else $error("data offset inside header");

   // one request in flight: no accept on the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken back to back");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid out of reset");

endmodule

bind first_fit_heap_allocator_unit ffha_checker #(
   .HEADER_BYTES (HEADER_BYTES)
) u_ffha_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
